// File: hdl/lconv_pkg.sv
// Shared constants, command codes and sequencer states for the convolution core.
package lconv_pkg;

  localparam int MAX_TAPS = 256;
  localparam int TAP_AW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TAP_CW   = $clog2(MAX_TAPS + 1);
  localparam int RAM_DEPTH = 1 << TAP_AW;

  localparam int DATA_W = 16;
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = 40;
  localparam int CMD_W  = 2;

  localparam logic [CMD_W-1:0] CMD_COEF   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FIN
  } state_t;

endpackage

// File: hdl/lconv_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lconv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/linear_convolution_core.sv
// Full linear convolution core: kernel load, sample/flush handling, shared MAC walk.
//
//  channel | dir | ports                                   | handshake
//  --------+-----+-----------------------------------------+---------------------
//  in      | in  | in_command, in_value, in_last           | in_valid / in_ready
//  out     | out | out_sum, out_final_res                  | out_valid / out_ready
//
// A sample or a tail flush walks the loaded taps (a sample with no taps loaded goes straight
// to the result): one multiply-accumulate per tap through the single shared multiplier,
// reading the kernel RAM and the circular delay-line RAM one address each per cycle.
// A flush with no tail left and an unused command are taken and emit nothing.
// Reset is synchronous and clears control state only; the delay line reads as zero
// through a fill count, so no clearing pass runs. A stalled output holds the result
// register; new requests are still taken until a second result has to wait for it.
module linear_convolution_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [lconv_pkg::CMD_W-1:0]           in_command,
  input  logic signed [lconv_pkg::DATA_W-1:0]   in_value,
  input  logic                                  in_last,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [lconv_pkg::ACC_W-1:0]    out_sum,
  output logic                                  out_final_res
);

  import lconv_pkg::*;

  state_t state_r, state_nxt;

  logic [TAP_CW-1:0] tap_cnt_r, tap_cnt_nxt;
  logic [TAP_CW-1:0] flush_r, flush_nxt;
  logic [TAP_CW-1:0] fill_r, fill_nxt;
  logic [TAP_CW-1:0] k_r, k_nxt;
  logic [TAP_AW-1:0] head_r, head_nxt;
  logic              kdone_r, kdone_nxt;
  logic              final_r, final_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [ACC_W-1:0] out_sum_r, out_sum_nxt;
  logic                    out_final_r, out_final_nxt;

  logic s1_v_r, s1_dv_r, s1_last_r;
  logic s2_v_r, s2_last_r;
  logic signed [PROD_W-1:0] p_r;

  logic                     issue;
  logic                     kwe;
  logic [TAP_AW-1:0]        kwaddr;
  logic                     dwe;
  logic signed [DATA_W-1:0] dwdata;
  logic signed [DATA_W-1:0] kdata;
  logic signed [DATA_W-1:0] ddata;
  logic signed [DATA_W-1:0] dsel;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W:0]    sum_ext;
  logic signed [ACC_W-1:0]  acc_sat;
  logic [TAP_AW-1:0]        draddr;

  lconv_ram #(.WIDTH(DATA_W), .DEPTH(RAM_DEPTH)) u_kram (
    .clk   (clk),
    .we    (kwe),
    .waddr (kwaddr),
    .wdata (in_value),
    .raddr (k_r[TAP_AW-1:0]),
    .rdata (kdata)
  );

  // Newest sample sits at head; tap k reads head + k.
  assign draddr = head_r + k_r[TAP_AW-1:0];

  lconv_ram #(.WIDTH(DATA_W), .DEPTH(RAM_DEPTH)) u_dram (
    .clk   (clk),
    .we    (dwe),
    .waddr (head_nxt),
    .wdata (dwdata),
    .raddr (draddr),
    .rdata (ddata)
  );

  // Entries beyond the fill count were never shifted in this job: treat as zero.
  assign dsel = s1_dv_r ? ddata : '0;
  assign prod = PROD_W'(kdata) * PROD_W'(dsel);

  assign sum_ext = {acc_r[ACC_W-1], acc_r} +
                   {{(ACC_W+1-PROD_W){p_r[PROD_W-1]}}, p_r};

  always_comb begin
    if (sum_ext[ACC_W] != sum_ext[ACC_W-1]) begin
      acc_sat = sum_ext[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_sat = sum_ext[ACC_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    tap_cnt_nxt   = tap_cnt_r;
    flush_nxt     = flush_r;
    fill_nxt      = fill_r;
    k_nxt         = k_r;
    head_nxt      = head_r;
    kdone_nxt     = kdone_r;
    final_nxt     = final_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_sum_nxt   = out_sum_r;
    out_final_nxt = out_final_r;
    in_ready      = (state_r == ST_IDLE);
    issue         = 1'b0;
    kwe           = 1'b0;
    kwaddr        = tap_cnt_r[TAP_AW-1:0];
    dwe           = 1'b0;
    dwdata        = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_command)
            CMD_COEF: begin
              if (kdone_r) begin
                // start a new job: drop old kernel and delay line
                kwe         = 1'b1;
                kwaddr      = '0;
                tap_cnt_nxt = TAP_CW'(1);
                flush_nxt   = '0;
                fill_nxt    = '0;
                kdone_nxt   = in_last;
              end else begin
                if (tap_cnt_r < TAP_CW'(MAX_TAPS)) begin
                  kwe         = 1'b1;
                  tap_cnt_nxt = tap_cnt_r + TAP_CW'(1);
                end
                if (in_last) begin
                  kdone_nxt = 1'b1;
                end
              end
            end
            CMD_SAMPLE: begin
              dwe       = 1'b1;
              dwdata    = in_value;
              head_nxt  = head_r - TAP_AW'(1);
              if (fill_r < TAP_CW'(MAX_TAPS)) begin
                fill_nxt = fill_r + TAP_CW'(1);
              end
              flush_nxt = (tap_cnt_r != '0) ? tap_cnt_r - TAP_CW'(1) : '0;
              final_nxt = 1'b0;
              acc_nxt   = '0;
              k_nxt     = '0;
              state_nxt = (tap_cnt_r == '0) ? ST_FIN : ST_WALK;
            end
            CMD_FLUSH: begin
              if (flush_r != '0) begin
                dwe       = 1'b1;
                head_nxt  = head_r - TAP_AW'(1);
                if (fill_r < TAP_CW'(MAX_TAPS)) begin
                  fill_nxt = fill_r + TAP_CW'(1);
                end
                flush_nxt = flush_r - TAP_CW'(1);
                final_nxt = (flush_r == TAP_CW'(1));
                acc_nxt   = '0;
                k_nxt     = '0;
                state_nxt = ST_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        issue = 1'b1;
        k_nxt = k_r + TAP_CW'(1);
        if (k_r == tap_cnt_r - TAP_CW'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (s2_v_r && s2_last_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = acc_r;
          out_final_nxt = final_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (s2_v_r) begin
      acc_nxt = acc_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tap_cnt_r   <= '0;
      flush_r     <= '0;
      fill_r      <= '0;
      k_r         <= '0;
      head_r      <= '0;
      kdone_r     <= 1'b0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tap_cnt_r   <= tap_cnt_nxt;
      flush_r     <= flush_nxt;
      fill_r      <= fill_nxt;
      k_r         <= k_nxt;
      head_r      <= head_nxt;
      kdone_r     <= kdone_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
      s1_v_r      <= issue;
      s2_v_r      <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    out_sum_r   <= out_sum_nxt;
    out_final_r <= out_final_nxt;
    s1_dv_r     <= (k_r < fill_r);
    s1_last_r   <= (k_r == tap_cnt_r - TAP_CW'(1));
    s2_last_r   <= s1_last_r;
    p_r         <= prod;
  end

  assign out_valid     = out_valid_r;
  assign out_sum       = out_sum_r;
  assign out_final_res = out_final_r;

`ifndef SYNTHESIS
  a_pipe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (state_r == ST_WALK || state_r == ST_DRAIN))
    else $error("MAC pipeline active outside the tap walk");

  a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tap_cnt_r <= TAP_CW'(MAX_TAPS))
    else $error("tap count beyond kernel capacity");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= TAP_CW'(MAX_TAPS))
    else $error("delay-line fill count beyond capacity");

  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_command == CMD_SAMPLE) |=> (state_r != ST_IDLE))
    else $error("sample request did not start a walk");
`endif

endmodule

// File: sim/tb.sv
// Self-checking testbench for the full linear convolution core.
`timescale 1ns / 100ps

module tb;
  import lconv_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = MAX_TAPS + 40;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } conv_req_t;

  typedef struct {
    logic signed [ACC_W-1:0] sum;
    logic                    final_res;
  } conv_out_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [CMD_W-1:0]         in_command = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     in_last = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [ACC_W-1:0]  out_sum;
  logic                     out_final_res;

  conv_req_t request_q[$];
  conv_out_t predicted_y_q[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int stim_count = 0;
  int y_count = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // convolution state as the core should hold it
  logic signed [DATA_W-1:0] h_taps [MAX_TAPS];
  logic signed [DATA_W-1:0] x_line [MAX_TAPS];
  int unsigned              n_taps = 0;
  bit                       kernel_closed = 1'b0;
  int unsigned              tail_left = 0;

  linear_convolution_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_value      (in_value),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sum       (out_sum),
    .out_final_res (out_final_res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void shift_line(input logic signed [DATA_W-1:0] s);
    for (int k = MAX_TAPS - 1; k > 0; k--) x_line[k] = x_line[k-1];
    x_line[0] = s;
  endfunction

  function automatic logic signed [ACC_W-1:0] mac_walk();
    longint acc;
    acc = 0;
    for (int k = 0; k < n_taps; k++) begin
      acc += longint'(h_taps[k]) * longint'(x_line[k]);
      // saturate after every add, not only at the end
      if (acc > longint'(ACC_MAX)) acc = longint'(ACC_MAX);
      else if (acc < longint'(ACC_MIN)) acc = longint'(ACC_MIN);
    end
    return acc[ACC_W-1:0];
  endfunction

  function automatic bit conv_predict(input conv_req_t req, output conv_out_t y);
    bit has_y;
    has_y = 1'b0;
    y.sum = '0;
    y.final_res = 1'b0;
    case (req.command)
      CMD_COEF: begin
        if (kernel_closed) begin
          n_taps = 0;
          kernel_closed = 1'b0;
          tail_left = 0;
          foreach (x_line[k]) x_line[k] = '0;
        end
        // drop taps past the store size
        if (n_taps < MAX_TAPS) begin
          h_taps[n_taps] = req.value;
          n_taps++;
        end
        if (req.last) kernel_closed = 1'b1;
      end
      CMD_SAMPLE: begin
        shift_line(req.value);
        y.sum = mac_walk();
        tail_left = (n_taps > 0) ? n_taps - 1 : 0;
        has_y = 1'b1;
      end
      CMD_FLUSH: begin
        if (tail_left != 0) begin
          shift_line('0);
          y.sum = mac_walk();
          tail_left--;
          y.final_res = (tail_left == 0);
          has_y = 1'b1;
        end
      end
      default: ;
    endcase
    return has_y;
  endfunction

  task automatic report_mismatch(input string what, input logic [ACC_W-1:0] got,
                                 input logic [ACC_W-1:0] want);
    mismatch_count++;
    $display("[%0t] output %0d %s: got %0h, want %0h", $time, y_count, what, got, want);
  endtask

  task automatic push_req(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] val,
                          input logic last);
    request_q.push_back({cmd, val, last});
    if (cmd != CMD_UNUSED) stim_count++;
  endtask

  function automatic logic signed [DATA_W-1:0] rand_value();
    case ($urandom_range(15))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return '1;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  task automatic push_job(input int taps, input int samples, input int tail, input bit close);
    for (int i = 0; i < taps; i++) begin
      // now and then a sample arrives while the kernel is still loading
      if (i != 0 && $urandom_range(19) == 0) push_req(CMD_SAMPLE, rand_value(), 1'($urandom));
      push_req(CMD_COEF, rand_value(), close && (i == taps - 1));
    end
    for (int i = 0; i < samples; i++) push_req(CMD_SAMPLE, rand_value(), 1'($urandom));
    for (int i = 0; i < tail; i++) begin
      if ($urandom_range(29) == 0) push_req(CMD_UNUSED, rand_value(), 1'($urandom));
      push_req(CMD_FLUSH, rand_value(), 1'($urandom));
    end
  endtask

  task automatic push_random_jobs(input int n);
    int stop_at;
    int taps;
    int samples;
    int tail;
    stop_at = stim_count + n;
    while (stim_count < stop_at) begin
      taps = ($urandom_range(7) == 0) ? $urandom_range(12, 48) : $urandom_range(1, 8);
      samples = $urandom_range(1, 12);
      tail = taps - 1;
      case ($urandom_range(9))
        0: begin
          // cut the tail short, then resume the signal
          push_job(taps, samples, $urandom_range(0, tail), 1'b1);
          push_job(0, $urandom_range(1, 4), tail, 1'b1);
        end
        1: push_job(taps, samples, tail + $urandom_range(1, 3), 1'b1);
        2: push_job(taps, samples, $urandom_range(0, tail), 1'b0);
        default: push_job(taps, samples, tail, 1'b1);
      endcase
    end
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || in_valid || predicted_y_q.size() != 0) @(negedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    conv_req_t req;
    conv_out_t y;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        req = {in_command, in_value, in_last};
        if (conv_predict(req, y)) predicted_y_q.push_back(y);
      end
      if (!in_valid || in_ready) begin
        if (request_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          req = request_q.pop_front();
          in_valid <= 1'b1;
          in_command <= req.command;
          in_value <= req.value;
          in_last <= req.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long hold-off of the receiver
  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (!rst_n || hold_left != 0) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // output monitor
  always @(posedge clk) begin
    conv_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (predicted_y_q.size() == 0) begin
        report_mismatch("with none pending", out_sum, '0);
      end else begin
        want = predicted_y_q.pop_front();
        if (out_sum !== want.sum) report_mismatch("sum", out_sum, want.sum);
        if (out_final_res !== want.final_res)
          report_mismatch("final_res", ACC_W'(out_final_res), ACC_W'(want.final_res));
      end
      y_count++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    foreach (x_line[k]) x_line[k] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_req(CMD_SAMPLE, 16'sh1234, 1'b1);   // no taps yet: zero sum
    push_req(CMD_FLUSH, 16'sh7fff, 1'b0);    // nothing to flush
    push_req(CMD_UNUSED, 16'sh8000, 1'b1);
    push_req(CMD_COEF, 16'sh7fff, 1'b0);
    push_req(CMD_SAMPLE, 16'sh8000, 1'b0);   // kernel still open
    push_req(CMD_COEF, 16'sh8000, 1'b1);
    push_req(CMD_SAMPLE, 16'sh8000, 1'b0);
    push_req(CMD_SAMPLE, 16'sh7fff, 1'b1);
    push_req(CMD_FLUSH, '0, 1'b1);
    push_req(CMD_FLUSH, '0, 1'b0);           // tail already done
    push_req(CMD_COEF, 16'sh8000, 1'b1);     // new job with one tap
    push_req(CMD_SAMPLE, 16'sh8000, 1'b0);
    push_req(CMD_SAMPLE, 16'sh7fff, 1'b0);
    push_req(CMD_FLUSH, '0, 1'b0);           // one tap has no tail
    push_req(CMD_COEF, 16'sh4000, 1'b0);
    push_req(CMD_COEF, 16'shffff, 1'b0);
    push_req(CMD_COEF, 16'sh0005, 1'b1);
    push_req(CMD_SAMPLE, 16'sh0064, 1'b0);
    push_req(CMD_FLUSH, '0, 1'b0);
    push_req(CMD_SAMPLE, 16'shff38, 1'b0);   // signal resumes mid-tail
    push_req(CMD_FLUSH, '0, 1'b0);
    push_req(CMD_FLUSH, '0, 1'b0);
    push_req(CMD_UNUSED, 16'sh5555, 1'b0);
    wait_drained();

    // full kernel plus overflow taps, mostly at full scale, then the whole tail
    for (int i = 0; i < MAX_TAPS + 2; i++)
      push_req(CMD_COEF, ($urandom_range(3) == 0) ? rand_value() : 16'sh8000,
               i == MAX_TAPS + 1);
    push_req(CMD_SAMPLE, 16'sh8000, 1'b0);
    push_req(CMD_SAMPLE, 16'sh8000, 1'b0);
    push_req(CMD_SAMPLE, 16'sh7fff, 1'b0);
    for (int i = 0; i < MAX_TAPS; i++) push_req(CMD_FLUSH, '0, 1'($urandom));
    push_random_jobs(50);
    wait_drained();

    idle_pct = 85;
    stall_pct = 0;
    push_random_jobs(70);
    wait_drained();

    idle_pct = 0;
    stall_pct = 85;
    push_random_jobs(70);
    wait_drained();

    idle_pct = 29;
    stall_pct = 29;
    push_random_jobs(70);
    wait_drained();

    // hold the receiver off while requests keep coming
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 2000;
    push_job(6, 60, 5, 1'b1);
    wait_drained();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: linear_convolution_core.f
hdl/lconv_pkg.sv
hdl/lconv_ram.sv
hdl/linear_convolution_core.sv
sim/tb.sv
